[rtl/core/spmd_pkg.sv]
// ----------------------------------------------------------------------------
// spmd_pkg
// Shared types, constants and helpers of the signed point-mesh distance block.
// ----------------------------------------------------------------------------
`default_nettype none

package spmd_pkg;

    localparam int FRAC_BITS = 16;              // Q16.16
    localparam int CRD_W     = 32;              // coordinate width
    localparam int ANG_W     = 18;              // angle width
    localparam int TOL_W     = 16;              // tolerance width
    localparam int SUM_W     = 48;              // offset sum width
    localparam int OFF_W     = 35;              // vertex offset after scaling
    localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(1);

    typedef enum logic {
        SQDIV_SQRT = 1'b0,
        SQDIV_DIV  = 1'b1
    } t_sqdiv_mode;

    typedef struct packed {
        logic        start;
        t_sqdiv_mode mode;
    } t_sqdiv_req;

    // difference of two signed coordinates, saturated to the coordinate width
    function automatic logic signed [CRD_W-1:0] sdiff(input logic signed [CRD_W-1:0] a,
                                                     input logic signed [CRD_W-1:0] b);
        logic signed [CRD_W:0] d;
        d = {a[CRD_W-1], a} - {b[CRD_W-1], b};
        if (d[CRD_W] != d[CRD_W-1]) begin
            return d[CRD_W] ? {1'b1, {(CRD_W-1){1'b0}}} : {1'b0, {(CRD_W-1){1'b1}}};
        end
        return d[CRD_W-1:0];
    endfunction

endpackage

`default_nettype wire

[rtl/core/signed_point_mesh_distance.sv]
// ----------------------------------------------------------------------------
// signed_point_mesh_distance
// Signed distance of a point to a mesh, one triangle per transaction, with a
// shared multiplier and a shared root/divide unit under a small sequencer.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-------------------------------
//  in      | in        | i_in_valid/o_in_ready  | point, vertices, angles, last
//  out     | out       | o_out_valid/i_out_ready| o_signed_distance
//  cfg     | in        | i_cfg_valid/o_cfg_ready| i_cfg_tie_tolerance
//
//  Root/divide use: the vertex case takes one root; the edge case takes a root
//  of |e|^2, a divide and a final root, all on the shared unit.
//  Reset: synchronous, active low; best distance to all ones, sum to zero,
//  tolerance to 1. Stalls: a held result on the out channel only blocks
//  the next last-triangle transaction from finishing; cfg is always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module signed_point_mesh_distance
    import spmd_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_in_valid,
    output logic                         o_in_ready,
    input  wire logic signed [CRD_W-1:0] i_local_x,
    input  wire logic signed [CRD_W-1:0] i_local_y,
    input  wire logic signed [CRD_W-1:0] i_local_z,
    input  wire logic signed [CRD_W-1:0] i_second_vertex_z,
    input  wire logic signed [CRD_W-1:0] i_third_vertex_y,
    input  wire logic signed [CRD_W-1:0] i_third_vertex_z,
    input  wire logic [ANG_W-1:0]        i_angle_at_a,
    input  wire logic [ANG_W-1:0]        i_angle_at_b,
    input  wire logic [ANG_W-1:0]        i_angle_at_c,
    input  wire logic                    i_last_triangle,
    output logic                         o_out_valid,
    input  wire logic                    i_out_ready,
    output logic signed [CRD_W-1:0]      o_signed_distance,
    input  wire logic                    i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire logic [TOL_W-1:0]        i_cfg_tie_tolerance
);

    typedef enum logic [4:0] {
        S_IDLE, S_C0, S_C1, S_C2, S_C3, S_C4, S_C5,
        S_D0, S_D1, S_D2, S_D3, S_D4,
        S_V0, S_V1, S_V2, S_V3, S_V4,
        S_E0, S_E1, S_E2, S_E3, S_E4, S_E5, S_E6, S_E7,
        S_WD, S_UPD, S_OUT
    } t_state;

    t_state r_state;

    // latched transaction
    logic signed [CRD_W-1:0] r_x, r_y, r_z, r_bz, r_cy, r_cz;
    logic [ANG_W-1:0]        r_ang_a, r_ang_b, r_ang_c;
    logic                    r_last;

    // classification and edge set-up
    logic                    r_e12n, r_e31n;
    logic signed [CRD_W-1:0] r_qz, r_ey, r_ez, r_wy, r_wz, r_vy, r_vz;
    logic [ANG_W-1:0]        r_ang_s, r_ang_e, r_ang_v;

    // arithmetic
    logic signed [65:0]      r_prod;
    logic signed [66:0]      r_acc;
    logic [63:0]             r_dm, r_l2;
    logic [31:0]             r_d, r_dist;
    logic signed [OFF_W-1:0] r_off;

    // running state
    logic [31:0]             r_best;
    logic signed [SUM_W-1:0] r_sum;
    logic [TOL_W-1:0]        r_tol;
    logic                    r_out_valid;
    logic signed [CRD_W-1:0] r_out;

    // shared multiplier operands
    logic signed [32:0]      mul_a, mul_b;

    t_sqdiv_req              sq_req;
    logic [63:0]             sq_src;
    logic                    sq_busy;
    logic [63:0]             sq_quo;

    // combinational helpers
    logic signed [66:0]      prod_x;
    logic signed [66:0]      acc_add, acc_sub, acc_rsub;
    logic                    e23n;
    logic [64:0]             dsum;
    logic [63:0]             dsum_sat;
    logic [32:0]             best_lim;
    logic [31:0]             adiff;
    logic signed [SUM_W:0]   sum_ext;
    logic signed [SUM_W-1:0] sum_sat;
    logic                    take, tie;
    logic signed [CRD_W-1:0] out_val;

    assign prod_x   = {r_prod[65], r_prod};
    assign acc_add  = r_acc + prod_x;
    assign acc_sub  = r_acc - prod_x;
    assign acc_rsub = prod_x - r_acc;
    assign e23n     = (r_acc < prod_x);
    assign dsum     = {1'b0, r_acc[63:0]} + {1'b0, r_prod[63:0]};
    assign dsum_sat = dsum[64] ? {64{1'b1}} : dsum[63:0];

    // minimum with tolerance band
    assign best_lim = {1'b0, r_best} + {17'd0, r_tol};
    assign take     = ({1'b0, r_dist} <= best_lim);
    assign adiff    = (r_dist > r_best) ? (r_dist - r_best) : (r_best - r_dist);
    assign tie      = (adiff < {16'd0, r_tol});
    assign sum_ext  = {r_sum[SUM_W-1], r_sum}
                    + {{(SUM_W+1-OFF_W){r_off[OFF_W-1]}}, r_off};
    always_comb begin
        if (sum_ext[SUM_W] != sum_ext[SUM_W-1]) begin
            sum_sat = sum_ext[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                     : {1'b0, {(SUM_W-1){1'b1}}};
        end else begin
            sum_sat = sum_ext[SUM_W-1:0];
        end
    end

    // result: negated for a positive sum, saturated either way
    always_comb begin
        if (r_sum > 0) begin
            out_val = (r_best > 32'h8000_0000) ? 32'sh8000_0000 : -$signed(r_best);
        end else begin
            out_val = r_best[31] ? 32'sh7FFF_FFFF : $signed(r_best);
        end
    end

    // operand select for the multiplier and requests to the root/divide unit
    always_comb begin
        mul_a  = '0;
        mul_b  = '0;
        sq_req = '{start: 1'b0, mode: SQDIV_SQRT};
        sq_src = r_acc[63:0];
        case (r_state)
            S_C0: begin mul_a = {r_y[31], r_y};   mul_b = {r_bz[31], r_bz}; end
            S_C1: begin mul_a = {r_z[31], r_z};   mul_b = {r_cy[31], r_cy}; end
            S_C2: begin mul_a = {r_y[31], r_y};   mul_b = {r_cz[31], r_cz}; end
            S_C3: begin
                mul_a = {r_y[31], r_y};
                mul_b = 33'(signed'(sdiff(r_cz, r_bz)));
            end
            S_C4: begin
                mul_a = 33'(signed'(sdiff(r_z, r_bz)));
                mul_b = {r_cy[31], r_cy};
            end
            S_D0: begin mul_a = {r_ey[31], r_ey}; mul_b = {r_y[31], r_y};   end
            S_D1: begin mul_a = {r_ez[31], r_ez}; mul_b = {r_qz[31], r_qz}; end
            S_D2: begin mul_a = {r_ey[31], r_ey}; mul_b = {r_ey[31], r_ey}; end
            S_D3: begin mul_a = {r_ez[31], r_ez}; mul_b = {r_ez[31], r_ez}; end
            S_V0: begin mul_a = {r_x[31], r_x};   mul_b = {r_x[31], r_x};   end
            S_V1: begin mul_a = {r_vy[31], r_vy}; mul_b = {r_vy[31], r_vy}; end
            S_V2: begin mul_a = {r_vz[31], r_vz}; mul_b = {r_vz[31], r_vz}; end
            S_V3: begin mul_a = {r_x[31], r_x};   mul_b = {15'd0, r_ang_v}; end
            S_V4: begin
                sq_req = '{start: 1'b1, mode: SQDIV_SQRT};
                sq_src = r_acc[63:0];
            end
            S_E0: begin
                mul_a  = {r_y[31], r_y};
                mul_b  = {r_ez[31], r_ez};
                sq_req = '{start: 1'b1, mode: SQDIV_SQRT};
                sq_src = r_l2;
            end
            S_E1: begin mul_a = {r_qz[31], r_qz}; mul_b = {r_ey[31], r_ey}; end
            S_E3: begin
                sq_req = '{start: !sq_busy, mode: SQDIV_DIV};
                sq_src = r_acc[63:0];
            end
            S_E5: begin mul_a = {1'b0, r_d};      mul_b = {1'b0, r_d};      end
            S_E6: begin mul_a = {r_x[31], r_x};   mul_b = {r_x[31], r_x};   end
            S_E7: begin
                sq_req = '{start: 1'b1, mode: SQDIV_SQRT};
                sq_src = dsum_sat;
            end
            default: begin
            end
        endcase
    end

    spmd_sqdiv u_sqdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (sq_req),
        .i_src   (sq_src),
        .i_den   (sq_quo[31:0]),
        .o_busy  (sq_busy),
        .o_quo   (sq_quo)
    );

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_best      <= '1;
            r_sum       <= '0;
            r_tol       <= TOL_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_tol <= i_cfg_tie_tolerance;
            end
            // S_OUT reloads the result register itself
            if (r_out_valid && i_out_ready && r_state != S_OUT) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_x     <= i_local_x;
                        r_y     <= i_local_y;
                        r_z     <= i_local_z;
                        r_bz    <= i_second_vertex_z;
                        r_cy    <= i_third_vertex_y;
                        r_cz    <= i_third_vertex_z;
                        r_ang_a <= i_angle_at_a;
                        r_ang_b <= i_angle_at_b;
                        r_ang_c <= i_angle_at_c;
                        r_last  <= i_last_triangle;
                        r_state <= S_C0;
                    end
                end
                S_C0: r_state <= S_C1;
                S_C1: begin
                    r_e12n  <= r_prod[65];
                    r_state <= S_C2;
                end
                S_C2: begin
                    r_acc   <= prod_x;
                    r_state <= S_C3;
                end
                S_C3: begin
                    r_e31n  <= (r_acc < prod_x);
                    r_state <= S_C4;
                end
                S_C4: begin
                    r_acc   <= prod_x;
                    r_state <= S_C5;
                end
                S_C5: begin
                    if (!r_e12n && !r_e31n && !e23n) begin
                        // inside: distance is the normal offset
                        r_dist  <= r_x[31] ? 32'(-r_x) : r_x;
                        r_off   <= OFF_W'(r_x);
                        r_state <= S_UPD;
                    end else begin
                        if (r_e12n) begin
                            // edge AB
                            r_qz    <= r_z;
                            r_ey    <= '0;
                            r_ez    <= r_bz;
                            r_wy    <= r_y;
                            r_wz    <= sdiff(r_z, r_bz);
                            r_ang_s <= r_ang_a;
                            r_ang_e <= r_ang_b;
                        end else if (r_e31n) begin
                            // edge AC
                            r_qz    <= r_z;
                            r_ey    <= r_cy;
                            r_ez    <= r_cz;
                            r_wy    <= sdiff(r_y, r_cy);
                            r_wz    <= sdiff(r_z, r_cz);
                            r_ang_s <= r_ang_a;
                            r_ang_e <= r_ang_c;
                        end else begin
                            // edge BC
                            r_qz    <= sdiff(r_z, r_bz);
                            r_ey    <= r_cy;
                            r_ez    <= sdiff(r_cz, r_bz);
                            r_wy    <= sdiff(r_y, r_cy);
                            r_wz    <= sdiff(r_z, r_cz);
                            r_ang_s <= r_ang_b;
                            r_ang_e <= r_ang_c;
                        end
                        r_state <= S_D0;
                    end
                end
                S_D0: r_state <= S_D1;
                S_D1: begin
                    r_acc   <= prod_x;
                    r_state <= S_D2;
                end
                S_D2: begin
                    if (acc_add[66]) begin
                        // behind the start vertex
                        r_vy    <= r_y;
                        r_vz    <= r_qz;
                        r_ang_v <= r_ang_s;
                        r_state <= S_V0;
                    end else begin
                        r_dm    <= acc_add[63:0];
                        r_state <= S_D3;
                    end
                end
                S_D3: begin
                    r_acc   <= prod_x;
                    r_state <= S_D4;
                end
                S_D4: begin
                    r_l2 <= acc_add[63:0];
                    if (acc_add[63:0] != 64'd0 && r_dm <= acc_add[63:0]) begin
                        r_state <= S_E0;
                    end else begin
                        // past the end vertex, or a zero-length edge
                        r_vy    <= r_wy;
                        r_vz    <= r_wz;
                        r_ang_v <= r_ang_e;
                        r_state <= S_V0;
                    end
                end
                S_V0: r_state <= S_V1;
                S_V1: begin
                    r_acc   <= prod_x;
                    r_state <= S_V2;
                end
                S_V2: begin
                    r_acc   <= acc_add;
                    r_state <= S_V3;
                end
                S_V3: begin
                    r_acc   <= acc_add;
                    r_state <= S_V4;
                end
                S_V4: begin
                    // floor(x * angle / 2^FRAC_BITS)
                    r_off   <= r_prod[FRAC_BITS+OFF_W-1:FRAC_BITS];
                    r_state <= S_WD;
                end
                S_E0: r_state <= S_E1;
                S_E1: begin
                    r_acc   <= prod_x;
                    r_state <= S_E2;
                end
                S_E2: begin
                    // |cross| of q and e
                    r_acc   <= {3'd0, (acc_sub[66] ? acc_rsub[63:0] : acc_sub[63:0])};
                    r_state <= S_E3;
                end
                S_E3: begin
                    if (!sq_busy) begin
                        r_state <= S_E4;
                    end
                end
                S_E4: begin
                    if (!sq_busy) begin
                        r_d     <= (sq_quo[63:32] != 32'd0) ? 32'hFFFF_FFFF : sq_quo[31:0];
                        r_state <= S_E5;
                    end
                end
                S_E5: r_state <= S_E6;
                S_E6: begin
                    r_acc   <= prod_x;
                    r_state <= S_E7;
                end
                S_E7: begin
                    r_off   <= OFF_W'(r_x);
                    r_state <= S_WD;
                end
                S_WD: begin
                    if (!sq_busy) begin
                        r_dist  <= sq_quo[31:0];
                        r_state <= S_UPD;
                    end
                end
                S_UPD: begin
                    if (take) begin
                        r_best <= r_dist;
                        r_sum  <= tie ? sum_sat : SUM_W'(r_off);
                    end
                    r_state <= r_last ? S_OUT : S_IDLE;
                end
                S_OUT: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out       <= out_val;
                        r_out_valid <= 1'b1;
                        r_best      <= '1;
                        r_sum       <= '0;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready        = (r_state == S_IDLE);
    assign o_out_valid       = r_out_valid;
    assign o_signed_distance = r_out;
    assign o_cfg_ready       = 1'b1;

    a_idle_unit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !sq_busy)
        else $error("spmd: root/divide unit busy while idle");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_signed_distance)))
        else $error("spmd: result dropped or changed while waiting");

    a_upd_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD) |=> (r_state == S_OUT || r_state == S_IDLE))
        else $error("spmd: update not followed by output or idle");

endmodule

`default_nettype wire

[rtl/core/spmd_sqdiv.sv]
// ----------------------------------------------------------------------------
// spmd_sqdiv
// Shared iterative unit: 64-bit integer square root (2 bits a step) or
// 64 / 32 unsigned division (1 bit a step) on one compare-subtract.
// ----------------------------------------------------------------------------
`default_nettype none

module spmd_sqdiv
    import spmd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_sqdiv_req  i_req,
    input  wire logic [63:0] i_src,
    input  wire logic [31:0] i_den,
    output logic             o_busy,
    output logic [63:0]      o_quo
);

    logic        r_busy;
    t_sqdiv_mode r_mode;
    logic [5:0]  r_cnt;
    logic [33:0] r_rem;
    logic [63:0] r_src;
    logic [63:0] r_quo;
    logic [31:0] r_den;

    logic [33:0] sh;
    logic [33:0] trial;
    logic        ge;

    always_comb begin
        if (r_mode == SQDIV_SQRT) begin
            sh    = {r_rem[31:0], r_src[63:62]};
            trial = {r_quo[31:0], 2'b01};
        end else begin
            sh    = {r_rem[32:0], r_src[63]};
            trial = {2'b00, r_den};
        end
        ge = (sh >= trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_mode <= SQDIV_SQRT;
            r_cnt  <= '0;
        end else if (!r_busy) begin
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_mode <= i_req.mode;
                r_cnt  <= (i_req.mode == SQDIV_SQRT) ? 6'd31 : 6'd63;
                r_rem  <= '0;
                r_quo  <= '0;
                r_src  <= i_src;
                r_den  <= i_den;
            end
        end else begin
            r_rem <= ge ? (sh - trial) : sh;
            r_quo <= {r_quo[62:0], ge};
            r_src <= (r_mode == SQDIV_SQRT) ? {r_src[61:0], 2'b00} : {r_src[62:0], 1'b0};
            r_cnt <= r_cnt - 6'd1;
            if (r_cnt == 6'd0) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_quo;

    a_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_cnt == 6'd0) |=> !r_busy)
        else $error("sqdiv: did not finish on last step");

    a_launch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_busy && i_req.start) |=> r_busy)
        else $error("sqdiv: request not taken");

    a_root_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_mode == SQDIV_SQRT) |-> (r_quo[63:32] == 32'd0))
        else $error("sqdiv: root grew past 32 bits");

endmodule

`default_nettype wire
